// File: rtl/core/mtcr_pkg.sv
package mtcr_pkg;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNALIGNED = 2'd1;
    localparam logic [1:0] ERR_RANGE     = 2'd2;

    localparam logic [1:0] WORD_TIMER_LO   = 2'd0;
    localparam logic [1:0] WORD_TIMER_HI   = 2'd1;
    localparam logic [1:0] WORD_COMPARE_LO = 2'd2;
    localparam logic [1:0] WORD_COMPARE_HI = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] byte_offset;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
    } request_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  access_error;
        logic        timer_irq;
    } result_t;

endpackage

// File: rtl/core/machine_timer_compare_registers.sv
// Machine timer with a 64-bit count and a 64-bit compare value, reached as four
// 32-bit words at byte offsets 0, 4, 8 and 12 (count low, count high, compare low,
// compare high). An item is a tick, a read, a write or of the unused type; each
// yields exactly one result item. Reading a high word captures the matching low
// word, so the next low read returns a consistent half; a write to either half
// of a pair drops that capture. A tick reports timer_irq when the incremented
// count is strictly above the compare value; holding a pending bit is up to the
// consumer. The block takes one item per cycle while its results are taken; an
// input register and a result register bracket the combinational 64-bit
// increment and compare. While a result waits to be taken, one more item can
// still enter the input register.
module machine_timer_compare_registers (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [11:0] s_byte_offset,
    input  logic [31:0] s_write_data,
    input  logic [3:0]  s_byte_enable,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [1:0]  m_access_error,
    output logic        m_timer_irq
);

    logic               in_valid_reg;
    mtcr_pkg::request_t in_reg;
    logic               out_valid_reg;
    mtcr_pkg::result_t  out_reg;
    mtcr_pkg::result_t  out_next;

    logic [63:0] timer_count_reg;
    logic [63:0] timer_count_next;
    logic [63:0] compare_value_reg;
    logic [63:0] compare_value_next;
    logic [31:0] timer_low_latch_reg;
    logic [31:0] timer_low_latch_next;
    logic        timer_latch_valid_reg;
    logic        timer_latch_valid_next;
    logic [31:0] compare_low_latch_reg;
    logic [31:0] compare_low_latch_next;
    logic        compare_latch_valid_reg;
    logic        compare_latch_valid_next;

    logic        proc_fire;
    logic [1:0]  word_sel;
    logic [31:0] byte_mask;
    logic [31:0] old_word;
    logic [31:0] merged_word;
    logic [63:0] timer_inc;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign word_sel  = in_reg.byte_offset[3:2];
    assign timer_inc = timer_count_reg + 64'd1;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            byte_mask[8*i +: 8] = {8{in_reg.byte_enable[i]}};
        end
        case (word_sel)
            mtcr_pkg::WORD_TIMER_LO:   old_word = timer_count_reg[31:0];
            mtcr_pkg::WORD_TIMER_HI:   old_word = timer_count_reg[63:32];
            mtcr_pkg::WORD_COMPARE_LO: old_word = compare_value_reg[31:0];
            default:                   old_word = compare_value_reg[63:32];
        endcase
        merged_word = (in_reg.write_data & byte_mask) | (old_word & ~byte_mask);
    end

    always_comb begin
        timer_count_next         = timer_count_reg;
        compare_value_next       = compare_value_reg;
        timer_low_latch_next     = timer_low_latch_reg;
        timer_latch_valid_next   = timer_latch_valid_reg;
        compare_low_latch_next   = compare_low_latch_reg;
        compare_latch_valid_next = compare_latch_valid_reg;
        out_next                 = '0;

        case (in_reg.req_type)
            mtcr_pkg::REQ_TICK: begin
                timer_count_next   = timer_inc;
                out_next.timer_irq = timer_inc > compare_value_reg;
            end
            mtcr_pkg::REQ_READ, mtcr_pkg::REQ_WRITE: begin
                if (in_reg.byte_offset[1:0] != 2'd0) begin
                    out_next.access_error = mtcr_pkg::ERR_UNALIGNED;
                end else if (in_reg.byte_offset[11:4] != 8'd0) begin
                    out_next.access_error = mtcr_pkg::ERR_RANGE;
                end else if (in_reg.req_type == mtcr_pkg::REQ_WRITE) begin
                    case (word_sel)
                        mtcr_pkg::WORD_TIMER_LO: begin
                            timer_count_next[31:0] = merged_word;
                            timer_latch_valid_next = 1'b0;
                        end
                        mtcr_pkg::WORD_TIMER_HI: begin
                            timer_count_next[63:32] = merged_word;
                            timer_latch_valid_next  = 1'b0;
                        end
                        mtcr_pkg::WORD_COMPARE_LO: begin
                            compare_value_next[31:0] = merged_word;
                            compare_latch_valid_next = 1'b0;
                        end
                        default: begin
                            compare_value_next[63:32] = merged_word;
                            compare_latch_valid_next  = 1'b0;
                        end
                    endcase
                end else begin
                    case (word_sel)
                        mtcr_pkg::WORD_TIMER_LO: begin
                            if (timer_latch_valid_reg) begin
                                out_next.read_data     = timer_low_latch_reg;
                                timer_latch_valid_next = 1'b0;
                            end else begin
                                out_next.read_data = timer_count_reg[31:0];
                            end
                        end
                        mtcr_pkg::WORD_TIMER_HI: begin
                            timer_low_latch_next   = timer_count_reg[31:0];
                            timer_latch_valid_next = 1'b1;
                            out_next.read_data     = timer_count_reg[63:32];
                        end
                        mtcr_pkg::WORD_COMPARE_LO: begin
                            if (compare_latch_valid_reg) begin
                                out_next.read_data       = compare_low_latch_reg;
                                compare_latch_valid_next = 1'b0;
                            end else begin
                                out_next.read_data = compare_value_reg[31:0];
                            end
                        end
                        default: begin
                            compare_low_latch_next   = compare_value_reg[31:0];
                            compare_latch_valid_next = 1'b1;
                            out_next.read_data       = compare_value_reg[63:32];
                        end
                    endcase
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            timer_count_reg         <= '0;
            compare_value_reg       <= '0;
            timer_low_latch_reg     <= '0;
            timer_latch_valid_reg   <= 1'b0;
            compare_low_latch_reg   <= '0;
            compare_latch_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                out_valid_reg           <= 1'b1;
                timer_count_reg         <= timer_count_next;
                compare_value_reg       <= compare_value_next;
                timer_low_latch_reg     <= timer_low_latch_next;
                timer_latch_valid_reg   <= timer_latch_valid_next;
                compare_low_latch_reg   <= compare_low_latch_next;
                compare_latch_valid_reg <= compare_latch_valid_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.req_type    <= s_req_type;
            in_reg.byte_offset <= s_byte_offset;
            in_reg.write_data  <= s_write_data;
            in_reg.byte_enable <= s_byte_enable;
        end
        if (proc_fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = out_reg.read_data;
    assign m_access_error = out_reg.access_error;
    assign m_timer_irq    = out_reg.timer_irq;

    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_reg.req_type == mtcr_pkg::REQ_TICK
        |=> timer_count_reg == $past(timer_count_reg) + 64'd1)
        else $error("Tick did not advance the timer by one.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !proc_fire |=> $stable(timer_count_reg) && $stable(compare_value_reg))
        else $error("Timer state changed without an item being processed.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_access_error != mtcr_pkg::ERR_NONE
        |-> m_read_data == 32'd0 && !m_timer_irq)
        else $error("Error result carries data or an interrupt.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> m_valid)
        else $error("Processed item produced no result.");

endmodule

// File: test/tb_machine_timer_compare_registers.sv
`timescale 1ns / 1ps

module tb_machine_timer_compare_registers;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 570;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [11:0] s_byte_offset;
    logic [31:0] s_write_data;
    logic [3:0]  s_byte_enable;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_read_data;
    logic [1:0]  m_access_error;
    logic        m_timer_irq;

    logic [63:0] model_count;
    logic [63:0] model_compare;
    logic [31:0] model_count_latch;
    logic        model_count_latch_ok;
    logic [31:0] model_compare_latch;
    logic        model_compare_latch_ok;

    mtcr_pkg::result_t pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      items_sent = 0;
    int      send_idle_pct = 31;
    int      recv_idle_pct = 69;

    machine_timer_compare_registers dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_byte_offset  (s_byte_offset),
        .s_write_data   (s_write_data),
        .s_byte_enable  (s_byte_enable),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_access_error (m_access_error),
        .m_timer_irq    (m_timer_irq)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [11:0] word_offset(input logic [1:0] word);
        return {8'd0, word, 2'b00};
    endfunction

    // Applies one request to the timer state and returns the result it must produce.
    function automatic mtcr_pkg::result_t timer_model_step(input mtcr_pkg::request_t req);
        mtcr_pkg::result_t res;
        logic [9:0]  word;
        logic [31:0] lanes;
        res = '0;
        word = req.byte_offset[11:2];
        lanes = {{8{req.byte_enable[3]}}, {8{req.byte_enable[2]}},
                 {8{req.byte_enable[1]}}, {8{req.byte_enable[0]}}};
        if (req.req_type == mtcr_pkg::REQ_TICK) begin
            model_count = model_count + 64'd1;
            res.timer_irq = (model_count > model_compare);
        end else if (req.req_type == mtcr_pkg::REQ_READ
                     || req.req_type == mtcr_pkg::REQ_WRITE) begin
            if (req.byte_offset[1:0] != 2'b00) begin
                res.access_error = mtcr_pkg::ERR_UNALIGNED;
            end else if (word > 10'd3) begin
                res.access_error = mtcr_pkg::ERR_RANGE;
            end else if (req.req_type == mtcr_pkg::REQ_WRITE) begin
                case (word[1:0])
                    mtcr_pkg::WORD_TIMER_LO: begin
                        model_count[31:0] = (req.write_data & lanes)
                                          | (model_count[31:0] & ~lanes);
                        model_count_latch_ok = 1'b0;
                    end
                    mtcr_pkg::WORD_TIMER_HI: begin
                        model_count[63:32] = (req.write_data & lanes)
                                           | (model_count[63:32] & ~lanes);
                        model_count_latch_ok = 1'b0;
                    end
                    mtcr_pkg::WORD_COMPARE_LO: begin
                        model_compare[31:0] = (req.write_data & lanes)
                                            | (model_compare[31:0] & ~lanes);
                        model_compare_latch_ok = 1'b0;
                    end
                    default: begin
                        model_compare[63:32] = (req.write_data & lanes)
                                             | (model_compare[63:32] & ~lanes);
                        model_compare_latch_ok = 1'b0;
                    end
                endcase
            end else begin
                case (word[1:0])
                    mtcr_pkg::WORD_TIMER_LO: begin
                        if (model_count_latch_ok) begin
                            res.read_data = model_count_latch;
                            model_count_latch_ok = 1'b0;
                        end else begin
                            res.read_data = model_count[31:0];
                        end
                    end
                    mtcr_pkg::WORD_TIMER_HI: begin
                        model_count_latch = model_count[31:0];
                        model_count_latch_ok = 1'b1;
                        res.read_data = model_count[63:32];
                    end
                    mtcr_pkg::WORD_COMPARE_LO: begin
                        if (model_compare_latch_ok) begin
                            res.read_data = model_compare_latch;
                            model_compare_latch_ok = 1'b0;
                        end else begin
                            res.read_data = model_compare[31:0];
                        end
                    end
                    default: begin
                        model_compare_latch = model_compare[31:0];
                        model_compare_latch_ok = 1'b1;
                        res.read_data = model_compare[63:32];
                    end
                endcase
            end
        end
        return res;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [11:0] offset,
                                input logic [31:0] data, input logic [3:0] enables);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_byte_offset <= offset;
        s_write_data  <= data;
        s_byte_enable <= enables;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_results.push_back(timer_model_step({kind, offset, data, enables}));
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        mtcr_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result item: data=%h error=%0d irq=%0b",
                             m_read_data, m_access_error, m_timer_irq);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_read_data !== want.read_data || m_access_error !== want.access_error
                        || m_timer_irq !== want.timer_irq) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch at %0t: exp %h %0d %0b got %h %0d %0b",
                                 $realtime, want.read_data, want.access_error,
                                 want.timer_irq, m_read_data, m_access_error,
                                 m_timer_irq);
                    end
                end
            end
        end
    end

    task automatic test_reset_state();
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_TIMER_LO), 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_TIMER_HI), 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_COMPARE_LO), 32'd0,
                     4'h0);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_COMPARE_HI), 32'd0,
                     4'h0);
    endtask

    task automatic test_access_errors();
        send_request(mtcr_pkg::REQ_READ, 12'h001, 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_WRITE, 12'h002, 32'hFFFF_FFFF, 4'hF);
        send_request(mtcr_pkg::REQ_READ, 12'h010, 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_WRITE, 12'hFFC, 32'hFFFF_FFFF, 4'hF);
        // Misalignment is reported even when the offset is also out of range.
        send_request(mtcr_pkg::REQ_READ, 12'hFFF, 32'd0, 4'h0);
        send_request(REQ_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 4'hF);
    endtask

    task automatic test_byte_lanes();
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_HI),
                     32'hFFFF_FFFF, 4'hF);
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_LO),
                     32'hA5A5_A5A5, 4'h0);
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_LO),
                     32'h1234_5678, 4'h5);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_COMPARE_LO), 32'd0,
                     4'h0);
    endtask

    task automatic test_latch_and_wrap();
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_TIMER_LO),
                     32'hFFFF_FFFF, 4'hF);
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_TIMER_HI),
                     32'hFFFF_FFFF, 4'hF);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_TIMER_HI), 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_TICK, 12'd0, 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_TIMER_LO), 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_TIMER_LO), 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_COMPARE_HI), 32'd0,
                     4'h0);
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_HI), 32'd0,
                     4'hF);
        send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_LO), 32'd1,
                     4'hF);
        send_request(mtcr_pkg::REQ_READ, word_offset(mtcr_pkg::WORD_COMPARE_LO), 32'd0,
                     4'h0);
        // The first tick makes the count equal to the compare value, the second passes it.
        send_request(mtcr_pkg::REQ_TICK, 12'd0, 32'd0, 4'h0);
        send_request(mtcr_pkg::REQ_TICK, 12'd0, 32'd0, 4'h0);
    endtask

    task automatic test_random_traffic(input int count);
        int          first;
        int          pick;
        logic        paused;
        logic [1:0]  word;
        logic [11:0] offset;
        first = items_sent;
        paused = 1'b0;
        while (items_sent - first < count) begin
            if (!paused && items_sent - first >= count / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            word = 2'($urandom_range(3));
            if (pick < 35) begin
                send_request(mtcr_pkg::REQ_TICK, 12'($urandom_range(4095)), $urandom,
                             4'($urandom_range(15)));
            end else if (pick < 55) begin
                send_request(mtcr_pkg::REQ_READ, word_offset(word), $urandom,
                             4'($urandom_range(15)));
            end else if (pick < 63) begin
                // A high read, then some traffic, then the matching low read.
                word[0] = 1'b1;
                send_request(mtcr_pkg::REQ_READ, word_offset(word), 32'd0, 4'h0);
                repeat ($urandom_range(3)) begin
                    if ($urandom_range(4) == 0) begin
                        send_request(mtcr_pkg::REQ_WRITE,
                                     word_offset(2'($urandom_range(3))), $urandom,
                                     4'($urandom_range(15)));
                    end else begin
                        send_request(mtcr_pkg::REQ_TICK, 12'd0, 32'd0, 4'h0);
                    end
                end
                send_request(mtcr_pkg::REQ_READ, word_offset({word[1], 1'b0}), 32'd0, 4'h0);
            end else if (pick < 78) begin
                send_request(mtcr_pkg::REQ_WRITE, word_offset(word), $urandom,
                             4'($urandom_range(15)));
            end else if (pick < 83) begin
                send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_HI),
                             model_count[63:32], 4'hF);
                send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_COMPARE_LO),
                             model_count[31:0] + $urandom_range(3), 4'hF);
            end else if (pick < 86) begin
                send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_TIMER_HI),
                             32'hFFFF_FFFF, 4'hF);
                send_request(mtcr_pkg::REQ_WRITE, word_offset(mtcr_pkg::WORD_TIMER_LO),
                             32'hFFFF_FFFF - $urandom_range(3), 4'hF);
            end else if (pick < 94) begin
                offset = 12'($urandom_range(4095));
                if ($urandom_range(1) == 0) begin
                    offset[1:0] = 2'($urandom_range(1, 3));
                end else begin
                    offset[11:2] = 10'($urandom_range(4, 1023));
                    offset[1:0] = 2'b00;
                end
                send_request($urandom_range(1) ? mtcr_pkg::REQ_WRITE : mtcr_pkg::REQ_READ,
                             offset, $urandom, 4'($urandom_range(15)));
            end else begin
                send_request(REQ_UNUSED, 12'($urandom_range(4095)), $urandom,
                             4'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= mtcr_pkg::REQ_TICK;
        s_byte_offset <= 12'd0;
        s_write_data  <= 32'd0;
        s_byte_enable <= 4'h0;
        model_count            = 64'd0;
        model_compare          = 64'd0;
        model_count_latch      = 32'd0;
        model_count_latch_ok   = 1'b0;
        model_compare_latch    = 32'd0;
        model_compare_latch_ok = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_access_errors();
        test_byte_lanes();
        test_latch_and_wrap();
        test_random_traffic(RANDOM_ITEMS);

        send_idle_pct = 69;
        recv_idle_pct = 31;
        test_random_traffic(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: machine_timer_compare_registers.f
rtl/core/mtcr_pkg.sv
rtl/core/machine_timer_compare_registers.sv
test/tb_machine_timer_compare_registers.sv
